// ----- sv/gas_pkg.sv -----
// shared types, state codes and neighbor offset tables for the grid automaton step block
package gas_pkg;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic wdata;
    } t_mem_ctl;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam logic       KIND_WRITE = 1'b0;
    localparam logic       KIND_QUERY = 1'b1;

    localparam logic [3:0] NBR_STEPS = 4'd9;
    localparam logic [3:0] SELF_STEP = 4'd4;
    localparam logic [3:0] MAX_LIVE  = 4'd8;

    // row offset plus one for neighbor step 0..8
    function automatic logic [1:0] step_dr(input logic [3:0] s);
        logic [1:0] d;
        case (s)
            4'd0, 4'd1, 4'd2: d = 2'd0;
            4'd3, 4'd4, 4'd5: d = 2'd1;
            4'd6, 4'd7, 4'd8: d = 2'd2;
            default:          d = 2'd1;
        endcase
        return d;
    endfunction

    // column offset plus one for neighbor step 0..8
    function automatic logic [1:0] step_dc(input logic [3:0] s);
        logic [1:0] d;
        case (s)
            4'd0, 4'd3, 4'd6: d = 2'd0;
            4'd1, 4'd4, 4'd7: d = 2'd1;
            4'd2, 4'd5, 4'd8: d = 2'd2;
            default:          d = 2'd1;
        endcase
        return d;
    endfunction

endpackage

// ----- sv/grid_automaton_step.sv -----
// grid automaton step top level: cell store, neighbor count sequencer and result register
// a write item is taken in the idle state; a query inside the grid goes from idle through
// the run state to done and back to idle before the next item; one outside skips run
// the single store port paces the run state: the cell and its 8 neighbors, one a cycle
// a finished result waits in the output register while the next item is taken
// synchronous active-low reset restores the register defaults; the cell store is not cleared
module grid_automaton_step
    import gas_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // row[5:0], col[11:6], alive_in[12], zero fill
    input  logic        i_s_axis_tuser,   // kind
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // next_alive[0], live_count[4:1], out_of_range[5]
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [6:0]  i_cfg_data
);

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int AW      = $clog2(DEPTH);
    localparam int ROW_LIM = (MAX_ROWS > 127) ? 127 : MAX_ROWS;
    localparam int COL_LIM = (MAX_COLS > 127) ? 127 : MAX_COLS;

    localparam logic [2:0] CFG_GRID_ROWS   = 3'd0;
    localparam logic [2:0] CFG_GRID_COLS   = 3'd1;
    localparam logic [2:0] CFG_BIRTH_COUNT = 3'd2;
    localparam logic [2:0] CFG_SURVIVE_MIN = 3'd3;
    localparam logic [2:0] CFG_SURVIVE_MAX = 3'd4;

    logic [6:0] r_grid_rows, r_grid_cols;
    logic [3:0] r_birth_count, r_survive_min, r_survive_max;

    logic [1:0] r_state, n_state;
    logic [3:0] r_step, n_step;
    logic [5:0] r_row, n_row, r_col, n_col;
    logic [3:0] r_count, n_count;
    logic       r_self, n_self;
    logic       r_oor, n_oor;
    logic       r_prev_act, n_prev_act;
    logic       r_prev_off, n_prev_off;
    logic       r_prev_self, n_prev_self;
    logic       r_out_valid, n_out_valid;
    logic       r_out_next, n_out_next;
    logic [3:0] r_out_count, n_out_count;
    logic       r_out_oor, n_out_oor;

    logic [5:0] in_row, in_col;
    logic       in_alive, in_kind, in_acc;
    logic [6:0] eff_rows, eff_cols;
    logic [6:0] nr_p1, nc_p1, nr, nc;
    logic       nbr_off, in_store, next_alive;
    t_mem_ctl   mem_ctl;
    logic [AW-1:0] mem_addr;
    logic       mem_rdata;

    assign in_row   = i_s_axis_tdata[5:0];
    assign in_col   = i_s_axis_tdata[11:6];
    assign in_alive = i_s_axis_tdata[12];
    assign in_kind  = i_s_axis_tuser;
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);

    assign eff_rows = (r_grid_rows > 7'(ROW_LIM)) ? 7'(ROW_LIM) : r_grid_rows;
    assign eff_cols = (r_grid_cols > 7'(COL_LIM)) ? 7'(COL_LIM) : r_grid_cols;

    // neighbor position, offset by one so that row -1 is code 0
    assign nr_p1   = {1'b0, r_row} + {5'd0, step_dr(r_step)};
    assign nc_p1   = {1'b0, r_col} + {5'd0, step_dc(r_step)};
    assign nr      = nr_p1 - 7'd1;
    assign nc      = nc_p1 - 7'd1;
    assign nbr_off = (nr_p1 == 7'd0) || (nc_p1 == 7'd0) || (nr_p1 > eff_rows)
                     || (nc_p1 > eff_cols);

    assign in_store = (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);

    always_comb begin
        mem_ctl.wr_en = in_acc && (in_kind == KIND_WRITE) && in_store;
        mem_ctl.rd_en = (r_state == S_RUN) && (r_step < NBR_STEPS) && !nbr_off;
        mem_ctl.wdata = in_alive;
        if (r_state == S_IDLE) begin
            mem_addr = AW'(32'(in_row) * MAX_COLS + 32'(in_col));
        end else begin
            mem_addr = AW'(32'(nr) * MAX_COLS + 32'(nc));
        end
    end

    gas_cell_mem #(
        .DEPTH (DEPTH)
    ) u_cell_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .o_rdata (mem_rdata)
    );

    assign next_alive = r_self ? ((r_count >= r_survive_min) && (r_count <= r_survive_max))
                               : (r_count == r_birth_count);

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_row       = r_row;
        n_col       = r_col;
        n_count     = r_count;
        n_self      = r_self;
        n_oor       = r_oor;
        n_prev_act  = 1'b0;
        n_prev_off  = r_prev_off;
        n_prev_self = r_prev_self;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_next  = r_out_next;
        n_out_count = r_out_count;
        n_out_oor   = r_out_oor;

        case (r_state)
            S_IDLE: begin
                if (in_acc && (in_kind == KIND_QUERY)) begin
                    n_row   = in_row;
                    n_col   = in_col;
                    n_step  = 4'd0;
                    n_count = 4'd0;
                    n_self  = 1'b0;
                    n_oor   = ({1'b0, in_row} >= eff_rows) || ({1'b0, in_col} >= eff_cols);
                    n_state = n_oor ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                // consume the read issued last cycle
                if (r_prev_act) begin
                    if (r_prev_off) begin
                        n_count = r_count + 4'd1;
                    end else if (r_prev_self) begin
                        n_self = mem_rdata;
                    end else begin
                        n_count = r_count + {3'd0, mem_rdata};
                    end
                end
                if (r_step < NBR_STEPS) begin
                    n_prev_act  = 1'b1;
                    n_prev_off  = nbr_off;
                    n_prev_self = (r_step == SELF_STEP);
                    n_step      = r_step + 4'd1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_oor   = r_oor;
                    n_out_next  = r_oor ? 1'b0 : next_alive;
                    n_out_count = r_oor ? 4'd0 : r_count;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_prev_act    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_grid_rows   <= 7'd64;
            r_grid_cols   <= 7'd64;
            r_birth_count <= 4'd4;
            r_survive_min <= 4'd2;
            r_survive_max <= 4'd3;
        end else begin
            r_state     <= n_state;
            r_prev_act  <= n_prev_act;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GRID_ROWS:   r_grid_rows   <= i_cfg_data;
                    CFG_GRID_COLS:   r_grid_cols   <= i_cfg_data;
                    CFG_BIRTH_COUNT: r_birth_count <= i_cfg_data[3:0];
                    CFG_SURVIVE_MIN: r_survive_min <= i_cfg_data[3:0];
                    CFG_SURVIVE_MAX: r_survive_max <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
        r_step      <= n_step;
        r_row       <= n_row;
        r_col       <= n_col;
        r_count     <= n_count;
        r_self      <= n_self;
        r_oor       <= n_oor;
        r_prev_off  <= n_prev_off;
        r_prev_self <= n_prev_self;
        r_out_next  <= n_out_next;
        r_out_count <= n_out_count;
        r_out_oor   <= n_out_oor;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_oor, r_out_count, r_out_next};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_count <= MAX_LIVE))
        else $error("neighbor count above eight");

    a_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.wr_en && mem_ctl.rd_en))
        else $error("cell store read and written in one cycle");

    a_oor_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out_oor) |-> (r_out_count == 4'd0 && !r_out_next))
        else $error("out-of-grid result carries a count or a live state");

    a_run_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_step == NBR_STEPS) |=> (r_state == S_DONE))
        else $error("query sequence did not finish after the last neighbor");

endmodule

// ----- sv/gas_cell_mem.sv -----
// single-port one-bit cell store with registered read data
module gas_cell_mem
    import gas_pkg::*;
#(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  t_mem_ctl                 i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    output logic                     o_rdata
);

    logic r_mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_addr] <= i_ctl.wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- dv/grid_automaton_step_tb.sv -----
// self-checking testbench for grid_automaton_step: directed table, then randomized phases
module grid_automaton_step_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gas_pkg::*;

    localparam int         GRID_MAX      = 64;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         NUM_PHASES    = 20;
    localparam int         PHASE_ITEMS   = 85;

    localparam logic [2:0] REG_ROWS      = 3'd0;
    localparam logic [2:0] REG_COLS      = 3'd1;
    localparam logic [2:0] REG_BIRTH     = 3'd2;
    localparam logic [2:0] REG_SURV_MIN  = 3'd3;
    localparam logic [2:0] REG_SURV_MAX  = 3'd4;
    localparam logic [2:0] REG_IDX_LAST  = 3'd7;

    typedef struct packed {
        logic       next_alive;
        logic [3:0] live_count;
        logic       out_of_range;
    } t_cell_result;

    typedef enum {STEP_WRITE, STEP_QUERY, STEP_REGS} t_step_op;

    // for STEP_REGS: r = rows, c = cols, v = {birth, survive_min, survive_max} nibbles
    typedef struct {
        t_step_op op;
        int       r;
        int       c;
        int       v;
        bit       chk;
        int       e_next;
        int       e_count;
        int       e_oor;
    } t_dir_row;

    localparam int N_DIR = 24;

    t_dir_row dir_tab [N_DIR] = '{
        '{STEP_WRITE,   0,  0, 1,     0, 0, 0, 0},
        '{STEP_WRITE,   0,  1, 1,     0, 0, 0, 0},
        '{STEP_WRITE,   1,  0, 0,     0, 0, 0, 0},
        '{STEP_WRITE,   1,  1, 1,     0, 0, 0, 0},
        '{STEP_QUERY,   0,  0, 0,     1, 0, 7, 0},
        '{STEP_WRITE,  62, 62, 0,     0, 0, 0, 0},
        '{STEP_WRITE,  62, 63, 0,     0, 0, 0, 0},
        '{STEP_WRITE,  63, 62, 0,     0, 0, 0, 0},
        '{STEP_WRITE,  63, 63, 0,     0, 0, 0, 0},
        '{STEP_QUERY,  63, 63, 0,     1, 0, 5, 0},
        '{STEP_REGS,  127, 64, 'h508, 0, 0, 0, 0},
        '{STEP_QUERY,  63, 63, 0,     1, 1, 5, 0},
        '{STEP_QUERY,   0,  0, 0,     1, 1, 7, 0},
        '{STEP_REGS,    2,  2, 'hF80, 0, 0, 0, 0},
        '{STEP_QUERY,   0,  0, 0,     1, 0, 7, 0},
        '{STEP_QUERY,   2,  0, 0,     1, 0, 0, 1},
        '{STEP_QUERY,   0, 63, 0,     1, 0, 0, 1},
        '{STEP_REGS,    0,  0, 'h423, 0, 0, 0, 0},
        '{STEP_WRITE,   5,  5, 1,     0, 0, 0, 0},
        '{STEP_QUERY,   0,  0, 0,     1, 0, 0, 1},
        '{STEP_REGS,   64, 64, 'h423, 0, 0, 0, 0},
        '{STEP_WRITE,   0,  2, 0,     0, 0, 0, 0},
        '{STEP_WRITE,   1,  2, 1,     0, 0, 0, 0},
        '{STEP_QUERY,   0,  1, 0,     0, 0, 0, 0}
    };

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata  = '0;   // row[5:0], col[11:6], alive_in[12], zero fill
    logic        i_s_axis_tuser  = 1'b0; // kind
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;         // next_alive[0], live_count[4:1], out_of_range[5]
    logic        i_cfg_we        = 1'b0;
    logic [2:0]  i_cfg_idx       = '0;
    logic [6:0]  i_cfg_data      = '0;

    logic         cell_bits [GRID_MAX][GRID_MAX];
    bit           cell_set  [GRID_MAX][GRID_MAX];
    int           cfg_rows     = 64;
    int           cfg_cols     = 64;
    int           cfg_birth    = 4;
    int           cfg_surv_min = 2;
    int           cfg_surv_max = 3;
    t_cell_result pending_cells [$];
    int           bad_results  = 0;
    bit           no_gaps      = 1'b0;

    grid_automaton_step uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int eff_dim(int v);
        return (v > GRID_MAX) ? GRID_MAX : v;
    endfunction

    function automatic t_cell_result next_gen(int r, int c);
        t_cell_result res;
        int           rows_eff;
        int           cols_eff;
        int           live;
        int           rr;
        int           cc;
        res      = '0;
        rows_eff = eff_dim(cfg_rows);
        cols_eff = eff_dim(cfg_cols);
        if (r >= rows_eff || c >= cols_eff) begin
            res.out_of_range = 1'b1;
            return res;
        end
        live = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (dr == 0 && dc == 0) continue;
                rr = r + dr;
                cc = c + dc;
                if (rr < 0 || cc < 0 || rr >= rows_eff || cc >= cols_eff) live++;
                else if (cell_bits[rr][cc]) live++;
            end
        end
        if (cell_bits[r][c])
            res.next_alive = (live >= cfg_surv_min && live <= cfg_surv_max);
        else
            res.next_alive = (live == cfg_birth);
        res.live_count = 4'(live);
        return res;
    endfunction

    // a query in the grid may only touch cells that hold a written value
    function automatic bit cell_readable(int r, int c);
        int rr;
        int cc;
        if (r >= eff_dim(cfg_rows) || c >= eff_dim(cfg_cols)) return 1'b1;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                if (rr >= 0 && cc >= 0 && rr < GRID_MAX && cc < GRID_MAX && !cell_set[rr][cc])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 64;
            2:       return 127;
            3:       return $urandom_range(0, 127);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    task automatic send_item(input logic kind, input int r, input int c, input logic alive,
                             input bit typed, input t_cell_result typed_res);
        int           gap;
        t_cell_result exp_res;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {3'b000, alive, 6'(c), 6'(r)};
        do @(posedge i_clk); while (o_s_axis_tready !== 1'b1);
        if (kind == KIND_WRITE) begin
            cell_bits[r][c] = alive;
            cell_set[r][c]  = 1'b1;
        end else begin
            exp_res       = typed ? typed_res : next_gen(r, c);
            pending_cells = {pending_cells, exp_res};
        end
    endtask

    task automatic quiesce();
        i_s_axis_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // unused index gets junk too, it must leave every register alone
    task automatic set_regs(input int rows, input int cols, input int birth,
                            input int smin, input int smax);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_ROWS;
        i_cfg_data <= 7'(rows);
        @(posedge i_clk);
        cfg_rows = rows & 127;
        i_cfg_idx  <= REG_COLS;
        i_cfg_data <= 7'(cols);
        @(posedge i_clk);
        cfg_cols = cols & 127;
        i_cfg_idx  <= REG_BIRTH;
        i_cfg_data <= {3'($urandom), 4'(birth)};
        @(posedge i_clk);
        cfg_birth = birth & 15;
        i_cfg_idx  <= REG_SURV_MIN;
        i_cfg_data <= {3'($urandom), 4'(smin)};
        @(posedge i_clk);
        cfg_surv_min = smin & 15;
        i_cfg_idx  <= REG_SURV_MAX;
        i_cfg_data <= {3'($urandom), 4'(smax)};
        @(posedge i_clk);
        cfg_surv_max = smax & 15;
        i_cfg_idx  <= 3'($urandom_range(REG_SURV_MAX + 1, REG_IDX_LAST));
        i_cfg_data <= 7'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_cell_result want;
        if (i_rst_n && o_m_axis_tvalid === 1'b1 && i_m_axis_tready) begin
            if (pending_cells.size() == 0) begin
                $display("%0t result with none pending: expected none actual %h",
                         $time, o_m_axis_tdata);
                bad_results++;
            end else begin
                want = pending_cells.pop_front();
                if (o_m_axis_tdata[0] !== want.next_alive) begin
                    $display("%0t next_alive mismatch: expected %0d actual %0d",
                             $time, want.next_alive, o_m_axis_tdata[0]);
                    bad_results++;
                end
                if (o_m_axis_tdata[4:1] !== want.live_count) begin
                    $display("%0t live_count mismatch: expected %0d actual %0d",
                             $time, want.live_count, o_m_axis_tdata[4:1]);
                    bad_results++;
                end
                if (o_m_axis_tdata[5] !== want.out_of_range) begin
                    $display("%0t out_of_range mismatch: expected %0d actual %0d",
                             $time, want.out_of_range, o_m_axis_tdata[5]);
                    bad_results++;
                end
            end
        end
    end

    initial begin
        int stall;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_axis_tvalid !== 1'b1);
        end
    end

    initial begin
        #(5ms);
        $display("FAIL");
        $finish;
    end

    initial begin
        t_cell_result typed_res;
        int           rows;
        int           cols;
        int           smin;
        int           smax;
        int           birth;
        int           win_r;
        int           win_c;
        int           r;
        int           c;
        logic         kind;
        for (int i = 0; i < GRID_MAX; i++)
            for (int j = 0; j < GRID_MAX; j++)
                cell_bits[i][j] = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            typed_res.next_alive   = 1'(dir_tab[k].e_next);
            typed_res.live_count   = 4'(dir_tab[k].e_count);
            typed_res.out_of_range = 1'(dir_tab[k].e_oor);
            case (dir_tab[k].op)
                STEP_REGS: begin
                    quiesce();
                    set_regs(dir_tab[k].r, dir_tab[k].c, dir_tab[k].v[11:8],
                             dir_tab[k].v[7:4], dir_tab[k].v[3:0]);
                end
                STEP_WRITE: send_item(KIND_WRITE, dir_tab[k].r, dir_tab[k].c,
                                      1'(dir_tab[k].v), 1'b0, typed_res);
                default:    send_item(KIND_QUERY, dir_tab[k].r, dir_tab[k].c,
                                      1'b0, dir_tab[k].chk, typed_res);
            endcase
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            quiesce();
            case (phase)
                0: begin
                    rows = 1;
                    cols = 1;
                end
                1: begin
                    rows = 64;
                    cols = 64;
                end
                2: begin
                    rows = 127;
                    cols = 0;
                end
                default: begin
                    rows = pick_dim();
                    cols = pick_dim();
                end
            endcase
            birth = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            smin  = $urandom_range(0, 8);
            smax  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(smin, 8);
            set_regs(rows, cols, birth, smin, smax);
            no_gaps = ($urandom_range(0, 3) == 0);
            // work in a small window so neighborhoods fill up and queries get through
            win_r = (eff_dim(cfg_rows) > 5) ? $urandom_range(0, eff_dim(cfg_rows) - 5) : 0;
            win_c = (eff_dim(cfg_cols) > 5) ? $urandom_range(0, eff_dim(cfg_cols) - 5) : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 6) == 0) begin
                    r = $urandom_range(0, 63);
                    c = $urandom_range(0, 63);
                end else begin
                    r = win_r + $urandom_range(0, 5);
                    c = win_c + $urandom_range(0, 5);
                end
                kind = ($urandom_range(0, 9) < 6) ? KIND_QUERY : KIND_WRITE;
                if (kind == KIND_QUERY && !cell_readable(r, c)) kind = KIND_WRITE;
                send_item(kind, r, c, 1'($urandom_range(0, 1)), 1'b0, typed_res);
            end
        end
        no_gaps = 1'b0;

        quiesce();
        if (bad_results == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- grid_automaton_step.f -----
sv/gas_pkg.sv
sv/gas_cell_mem.sv
sv/grid_automaton_step.sv
dv/grid_automaton_step_tb.sv
